### sv/wear_level_slot_ring_manager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wear-level slot ring manager
// Concurrent checks sampled on the rising clock, muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef WEAR_LEVEL_SLOT_RING_MANAGER_ASSERT_SVH
`define WEAR_LEVEL_SLOT_RING_MANAGER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WLSRM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WLSRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wlsrm_pkg.sv
// ----------------------------------------------------------------------------
// wlsrm_pkg
// Shared types, codes and widths of the wear-level slot ring manager.
// ----------------------------------------------------------------------------
package wlsrm_pkg;

   localparam int MAX_SLOTS = 256;
   localparam int SLOT_W    = 8;
   localparam int CNT_W     = 9;
   localparam int ADDR_W    = 16;
   localparam int SEQ_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam int STEP_W    = 4;

   localparam logic [SEQ_W-1:0]  SEQ_HALF = 32'h8000_0000;
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(CNT_W - 1);

   typedef enum logic [2:0] {
      CMD_PLAN_SAVE   = 3'd0,
      CMD_COMMIT_SAVE = 3'd1,
      CMD_SCAN_BEGIN  = 3'd2,
      CMD_SCAN_HEADER = 3'd3,
      CMD_SCAN_END    = 3'd4,
      CMD_COMMIT_LOAD = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_AVAIL   = 2'd1,
      ST_NONE_FOUND  = 2'd2,
      ST_ACCESS_FAIL = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_READY     = 3'd0,
      CSR_BASE      = 3'd1,
      CSR_SLOT_SIZE = 3'd2,
      CSR_SLOT_CNT  = 3'd3,
      CSR_MAGIC     = 3'd4,
      CSR_VERSION   = 3'd5,
      CSR_COUNT     = 3'd6
   } csr_index_type;

   // Request payload, first member in the highest bits.
   typedef struct packed {
      logic [31:0] hdr_seq;
      logic [15:0] hdr_count;
      logic [7:0]  hdr_version;
      logic [31:0] hdr_magic;
      logic        access_ok;
   } req_fields_type;

   typedef struct packed {
      logic              scan_done;
      logic [SEQ_W-1:0]  sequence_res;
      logic [SLOT_W-1:0] slot_index;
      logic [ADDR_W-1:0] slot_address;
      status_type        status;
   } rsp_fields_type;

   localparam int REQ_FIELDS_W = $bits(req_fields_type);
   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = 3;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic div_step;
      logic mul;
      logic rsp_load;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_sts_type;

endpackage

### sv/wlsrm_ctrl.sv
// ----------------------------------------------------------------------------
// wlsrm_ctrl
// Sequencer: accept a beat, execute, optional modulo, multiply, deliver.
// ----------------------------------------------------------------------------
module wlsrm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output wlsrm_pkg::ctl_cmd_type  ctl,
   input  wlsrm_pkg::dp_sts_type   sts
);
   import wlsrm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_MUL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctl.load_req = (state_ff == S_IDLE) && req_tvalid;
      ctl.exec     = (state_ff == S_EXEC);
      ctl.div_step = (state_ff == S_DIV);
      ctl.mul      = (state_ff == S_MUL);
      ctl.rsp_load = (state_ff == S_OUT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_MUL;
            if (sts.need_div) state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_last) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/wlsrm_dp.sv
// ----------------------------------------------------------------------------
// wlsrm_dp
// Configuration, slot history, scan tracking, modulo unit and address math.
// ----------------------------------------------------------------------------
module wlsrm_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wlsrm_pkg::ctl_cmd_type                 ctl,
   output wlsrm_pkg::dp_sts_type                  sts,
   input  logic                                   csr_wr,
   input  logic [wlsrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wlsrm_pkg::CSR_DAT_W-1:0]        csr_data,
   input  logic [wlsrm_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic [wlsrm_pkg::REQ_TUSER_W-1:0]      req_tuser,
   output logic [wlsrm_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import wlsrm_pkg::*;

   // configuration
   logic              ready_cfg_ff;
   logic [ADDR_W-1:0] region_base_ff;
   logic [15:0]       slot_bytes_ff;
   logic [CNT_W-1:0]  slot_count_ff;
   logic [31:0]       exp_magic_ff;
   logic [7:0]        exp_version_ff;
   logic [15:0]       exp_count_ff;

   // latched request
   logic [REQ_TUSER_W-1:0] cmd_ff;
   req_fields_type         req_ff;

   // architectural state
   logic [SLOT_W-1:0] last_slot_ff,    last_slot_in;
   logic [SEQ_W-1:0]  last_seq_ff,     last_seq_in;
   logic              has_history_ff,  has_history_in;
   logic [SLOT_W-1:0] pend_slot_ff,    pend_slot_in;
   logic [SEQ_W-1:0]  pend_seq_ff,     pend_seq_in;
   logic [SLOT_W-1:0] lead_slot_ff,    lead_slot_in;
   logic [SEQ_W-1:0]  best_seq_ff,     best_seq_in;
   logic              best_found_ff,   best_found_in;
   logic [CNT_W-1:0]  scan_pos_ff,     scan_pos_in;

   // working result
   status_type        status_ff,    status_in;
   logic [SLOT_W-1:0] idx_ff,       idx_in;
   logic              zero_addr_ff, zero_addr_in;
   logic [SEQ_W-1:0]  sres_ff,      sres_in;
   logic              done_ff,      done_in;
   logic              need_div_ff,  need_div_in;

   // modulo unit and multiplier
   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [CNT_W-1:0]  dvd_ff,  dvd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]    trial;
   logic [ADDR_W-1:0] prod_ff, prod_in;
   logic [23:0]       mul_full;

   rsp_fields_type    rsp_ff, rsp_in;

   logic [CNT_W-1:0]  n_eff;
   logic [CNT_W-1:0]  pos_next;
   logic [SEQ_W-1:0]  seq_diff;
   logic              hdr_match;
   logic              hdr_newer;

   always_comb begin
      n_eff = slot_count_ff;
      if (slot_count_ff == '0) n_eff = CNT_W'(1);
      else if (slot_count_ff > CNT_W'(MAX_SLOTS)) n_eff = CNT_W'(MAX_SLOTS);
   end

   assign seq_diff  = req_ff.hdr_seq - best_seq_ff;
   assign hdr_newer = !best_found_ff || (seq_diff < SEQ_HALF);
   assign hdr_match = (req_ff.hdr_magic == exp_magic_ff) &&
                      (req_ff.hdr_version == exp_version_ff) &&
                      (req_ff.hdr_count == exp_count_ff);

   assign mul_full = {16'b0, idx_ff} * {8'b0, slot_bytes_ff};

   // the sequencer branches on this while it is still in the execute state
   assign sts.need_div = need_div_in;
   assign sts.div_last = (step_ff == DIV_LAST);

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, rsp_ff};

   always_comb begin
      last_slot_in   = last_slot_ff;
      last_seq_in    = last_seq_ff;
      has_history_in = has_history_ff;
      pend_slot_in   = pend_slot_ff;
      pend_seq_in    = pend_seq_ff;
      lead_slot_in   = lead_slot_ff;
      best_seq_in    = best_seq_ff;
      best_found_in  = best_found_ff;
      scan_pos_in    = scan_pos_ff;
      status_in      = status_ff;
      idx_in         = idx_ff;
      zero_addr_in   = zero_addr_ff;
      sres_in        = sres_ff;
      done_in        = done_ff;
      need_div_in    = need_div_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      step_in        = step_ff;
      prod_in        = prod_ff;
      rsp_in         = rsp_ff;
      pos_next       = scan_pos_ff;
      trial          = {rem_ff, dvd_ff[CNT_W-1]};

      if (ctl.exec) begin
         status_in    = ST_OK;
         idx_in       = '0;
         zero_addr_in = 1'b1;
         sres_in      = '0;
         done_in      = 1'b0;
         need_div_in  = 1'b0;
         if (!ready_cfg_ff || (cmd_ff > CMD_COMMIT_LOAD)) begin
            status_in = ST_NOT_AVAIL;
         end else begin
            case (cmd_ff)
               CMD_PLAN_SAVE: begin
                  zero_addr_in = 1'b0;
                  if ((n_eff > CNT_W'(1)) && has_history_ff) begin
                     // slot index arrives from the modulo unit
                     need_div_in = 1'b1;
                     dvd_in      = {1'b0, last_slot_ff} + CNT_W'(1);
                     rem_in      = '0;
                     step_in     = '0;
                     pend_seq_in = last_seq_ff + SEQ_W'(1);
                  end else begin
                     pend_slot_in = '0;
                     pend_seq_in  = SEQ_W'(1);
                  end
                  sres_in = pend_seq_in;
               end
               CMD_COMMIT_SAVE: begin
                  zero_addr_in = 1'b0;
                  idx_in       = pend_slot_ff;
                  sres_in      = pend_seq_ff;
                  if (req_ff.access_ok) begin
                     last_slot_in   = pend_slot_ff;
                     last_seq_in    = pend_seq_ff;
                     has_history_in = 1'b1;
                  end else begin
                     status_in = ST_ACCESS_FAIL;
                  end
               end
               CMD_SCAN_BEGIN: begin
                  pos_next      = '0;
                  scan_pos_in   = '0;
                  best_found_in = 1'b0;
                  lead_slot_in  = '0;
                  best_seq_in   = '0;
                  zero_addr_in  = 1'b0;
               end
               CMD_SCAN_HEADER: begin
                  if (scan_pos_ff < n_eff) begin
                     if (!req_ff.access_ok) begin
                        status_in = ST_ACCESS_FAIL;
                     end else if (hdr_match && hdr_newer) begin
                        lead_slot_in  = scan_pos_ff[SLOT_W-1:0];
                        best_seq_in   = req_ff.hdr_seq;
                        best_found_in = 1'b1;
                     end
                     pos_next = scan_pos_ff + CNT_W'(1);
                  end
                  scan_pos_in = pos_next;
                  if (pos_next < n_eff) begin
                     zero_addr_in = 1'b0;
                     idx_in       = pos_next[SLOT_W-1:0];
                  end
                  sres_in = best_seq_in;
               end
               CMD_SCAN_END: begin
                  if (best_found_ff) begin
                     zero_addr_in = 1'b0;
                     idx_in       = lead_slot_ff;
                     sres_in      = best_seq_ff;
                  end else begin
                     status_in = ST_NONE_FOUND;
                  end
               end
               CMD_COMMIT_LOAD: begin
                  if (!best_found_ff) begin
                     status_in = ST_NONE_FOUND;
                  end else begin
                     zero_addr_in = 1'b0;
                     idx_in       = lead_slot_ff;
                     sres_in      = best_seq_ff;
                     if (req_ff.access_ok) begin
                        last_slot_in   = lead_slot_ff;
                        last_seq_in    = best_seq_ff;
                        has_history_in = 1'b1;
                     end else begin
                        status_in = ST_ACCESS_FAIL;
                     end
                  end
               end
               default: begin
                  status_in = ST_NOT_AVAIL;
               end
            endcase
            done_in = (pos_next >= n_eff);
         end
      end

      // restoring remainder, one dividend bit per cycle
      if (ctl.div_step) begin
         if (trial >= {1'b0, n_eff}) trial = trial - {1'b0, n_eff};
         rem_in  = trial[CNT_W-1:0];
         dvd_in  = {dvd_ff[CNT_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == DIV_LAST) begin
            pend_slot_in = trial[SLOT_W-1:0];
            idx_in       = trial[SLOT_W-1:0];
         end
      end

      if (ctl.mul) prod_in = mul_full[ADDR_W-1:0];

      if (ctl.rsp_load) begin
         rsp_in.status       = status_ff;
         rsp_in.slot_address = zero_addr_ff ? '0 : (region_base_ff + prod_ff);
         rsp_in.slot_index   = idx_ff;
         rsp_in.sequence_res = sres_ff;
         rsp_in.scan_done    = done_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_cfg_ff   <= 1'b0;
         region_base_ff <= '0;
         slot_bytes_ff  <= 16'd1;
         slot_count_ff  <= CNT_W'(1);
         exp_magic_ff   <= '0;
         exp_version_ff <= '0;
         exp_count_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_READY:     ready_cfg_ff   <= csr_data[0];
            CSR_BASE:      region_base_ff <= csr_data[ADDR_W-1:0];
            CSR_SLOT_SIZE: slot_bytes_ff  <= csr_data[15:0];
            CSR_SLOT_CNT:  slot_count_ff  <= csr_data[CNT_W-1:0];
            CSR_MAGIC:     exp_magic_ff   <= csr_data[31:0];
            CSR_VERSION:   exp_version_ff <= csr_data[7:0];
            CSR_COUNT:     exp_count_ff   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_slot_ff   <= '0;
         last_seq_ff    <= '0;
         has_history_ff <= 1'b0;
         pend_slot_ff   <= '0;
         pend_seq_ff    <= '0;
         lead_slot_ff   <= '0;
         best_seq_ff    <= '0;
         best_found_ff  <= 1'b0;
         scan_pos_ff    <= '0;
         need_div_ff    <= 1'b0;
         step_ff        <= '0;
      end else begin
         last_slot_ff   <= last_slot_in;
         last_seq_ff    <= last_seq_in;
         has_history_ff <= has_history_in;
         pend_slot_ff   <= pend_slot_in;
         pend_seq_ff    <= pend_seq_in;
         lead_slot_ff   <= lead_slot_in;
         best_seq_ff    <= best_seq_in;
         best_found_ff  <= best_found_in;
         scan_pos_ff    <= scan_pos_in;
         need_div_ff    <= need_div_in;
         step_ff        <= step_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff <= req_tuser;
         req_ff <= req_fields_type'(req_tdata[REQ_FIELDS_W-1:0]);
      end
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      zero_addr_ff <= zero_addr_in;
      sres_ff      <= sres_in;
      done_ff      <= done_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      prod_ff      <= prod_in;
      rsp_ff       <= rsp_in;
   end

endmodule

### sv/wear_level_slot_ring_manager.sv
// ----------------------------------------------------------------------------
// wear_level_slot_ring_manager
// Round-robin slot planner and header scanner for one storage region.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and answers each with exactly one
// result beat. A command occupies the block from acceptance until its result
// is registered (accept, execute, slot*size multiply, address add), so a new
// command is not accepted before then. A plan save with history and more than
// one slot also passes through the bit-serial modulo unit that computes
// (last+1) mod slot count. The result sits in an output register, so the next
// command is accepted while a result waits; the block holds the following
// result until the earlier one is taken. There is no clearing pass after
// reset. Configuration writes are always taken (csr_ready tied high) and are
// meant for idle periods only.
// ----------------------------------------------------------------------------
module wear_level_slot_ring_manager (
   input  logic                                  clock,
   input  logic                                  reset,
   // command channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // access_ok, hdr_magic, hdr_version, hdr_count, hdr_seq (low bit up)
   input  logic [wlsrm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd
   input  logic [wlsrm_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // status, slot_address, slot_index, sequence_res, scan_done (low bit up)
   output logic [wlsrm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wlsrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wlsrm_pkg::CSR_DAT_W-1:0]       csr_data
);
   import wlsrm_pkg::*;

   ctl_cmd_type ctl;
   dp_sts_type  sts;

   // take every register write on the beat it is offered
   assign csr_ready = 1'b1;

   // sequencer: owns the handshakes and steps the datapath
   wlsrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .sts        (sts)
   );

   // datapath: registers, history, scan best, modulo and address math
   wlsrm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .csr_wr     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### sv/wlsrm_checker.sv
// ----------------------------------------------------------------------------
// wlsrm_checker
// Port-level checks of the slot ring manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "wear_level_slot_ring_manager_assert.svh"

module wlsrm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [wlsrm_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import wlsrm_pkg::*;

   rsp_fields_type         rsp_f;
   logic                   rsp_stall;
   logic [RSP_TDATA_W:0]   rsp_bus;
   logic                   req_beat;
   logic                   na_beat, na_clean;
   logic                   nf_beat, nf_clean;

   assign rsp_f     = rsp_fields_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_bus   = {rsp_tvalid, rsp_tdata};
   assign req_beat  = req_tvalid && req_tready;

   assign na_beat  = rsp_tvalid && (rsp_f.status == ST_NOT_AVAIL);
   assign na_clean = (rsp_f.slot_address == '0) && (rsp_f.slot_index == '0) &&
                     (rsp_f.sequence_res == '0) && !rsp_f.scan_done;
   assign nf_beat  = rsp_tvalid && (rsp_f.status == ST_NONE_FOUND);
   assign nf_clean = (rsp_f.slot_address == '0) && (rsp_f.slot_index == '0) &&
                     (rsp_f.sequence_res == '0);

   // a stalled result beat holds
   `WLSRM_ASSERT_NEXT(a_rsp_hold, rsp_stall, $stable(rsp_bus), "stalled result beat changed")

   // one command in flight: no accept right after an accept
   `WLSRM_ASSERT_NEXT(a_one_in_flight, req_beat, !req_tready, "command accepted while busy")

   // not available carries no slot, sequence or done flag
   `WLSRM_ASSERT_SAME(a_na_zero, na_beat, na_clean, "not-available result carries data")

   // nothing found names no slot
   `WLSRM_ASSERT_SAME(a_none_zero, nf_beat, nf_clean, "nothing-found result names a slot")

endmodule

bind wear_level_slot_ring_manager wlsrm_checker u_checker (.*);
